### hw/rtl/rrts_pkg.sv
// Shared types, codes and defaults for the round-robin task scheduler.
package rrts_pkg;

  localparam int TaskSlotsDefault = 8;
  localparam int LockCountDefault = 8;

  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_CREATE = 3'd1;
  localparam logic [2:0] OP_YIELD  = 3'd2;
  localparam logic [2:0] OP_SLEEP  = 3'd3;
  localparam logic [2:0] OP_EXIT   = 3'd4;
  localparam logic [2:0] OP_LOCK   = 3'd5;
  localparam logic [2:0] OP_UNLOCK = 3'd6;

  localparam logic [2:0] STS_OK      = 3'd0;
  localparam logic [2:0] STS_BAD_ID  = 3'd1;
  localparam logic [2:0] STS_NOT_OWN = 3'd2;
  localparam logic [2:0] STS_FULL    = 3'd3;
  localparam logic [2:0] STS_NO_RUN  = 3'd4;

  typedef enum logic [1:0] {
    TS_UNUSED  = 2'd0,
    TS_READY   = 2'd1,
    TS_SLEEP   = 2'd2,
    TS_BLOCKED = 2'd3
  } task_st_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_UNLK_RD,
    S_UNLK_WR,
    S_ROT,
    S_DONE
  } state_t;

  // ready queue command: push the given id and/or pop the head
  typedef struct packed {
    logic push;
    logic pop;
  } rq_cmd_t;

endpackage

### hw/rtl/round_robin_task_scheduler_unit.sv
// Top level of the round-robin task scheduler.
// One request at a time. Create, a disabled tick and any request that leaves the running
// task in place go through accept, execute and result. A request that switches tasks (yield,
// sleep, exit, a blocking lock, unlock) adds a ready-queue rotate step before the result.
// Unlock with a waiter first makes one waiter memory read before the handoff. An enabled
// tick reads the wake-time memory one slot per cycle to find due sleepers, then rotates.
// Wake times and mutex wait queues live in synchronous memories; a request is taken only
// while the result register is free or being emptied in the same cycle.
module round_robin_task_scheduler_unit #(
  parameter int TASK_SLOTS = rrts_pkg::TaskSlotsDefault,
  parameter int LOCK_COUNT = rrts_pkg::LockCountDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_enable,
  input  logic        cfg_write_data,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [2:0]  operation,
  input  logic [31:0] sleep_ticks,
  input  logic [7:0]  mutex_id,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [2:0]  running_id,
  output logic        running_ok,
  output logic [2:0]  result_status,
  output logic [2:0]  created_id,
  output logic [31:0] time_now
);
  import rrts_pkg::*;

  localparam int TW  = $clog2(TASK_SLOTS);
  localparam int CW  = $clog2(TASK_SLOTS + 1);
  localparam int LW  = (LOCK_COUNT > 1) ? $clog2(LOCK_COUNT) : 1;
  localparam int WD  = LOCK_COUNT * TASK_SLOTS;
  localparam int WAW = $clog2(WD);

  state_t state, state_next;

  logic          scheduler_enable;
  logic [2:0]    op;
  logic [31:0]   ticks;
  logic [7:0]    mid;
  logic [2:0]    status;
  logic [TW-1:0] created;
  logic [31:0]   tick_counter;
  logic [TW-1:0] cur;
  logic          cur_valid;

  task_st_t      task_state [TASK_SLOTS];
  logic          lock_held  [LOCK_COUNT];
  logic [TW-1:0] lock_owner [LOCK_COUNT];
  logic [TW-1:0] whead      [LOCK_COUNT];
  logic [CW-1:0] wcount     [LOCK_COUNT];

  logic [31:0]   wake_mem [TASK_SLOTS];
  logic [31:0]   wake_rd;
  logic [TW-1:0] wake_addr;
  logic [TW-1:0] waiter_mem [WD];
  logic [TW-1:0] waiter_rd;
  logic [WAW-1:0] waiter_raddr;
  logic [WAW-1:0] waiter_waddr;

  logic [CW-1:0] scan_cnt;
  logic          rd_vld;
  logic [TW-1:0] rd_idx;

  rq_cmd_t       q_cmd;
  logic [TW-1:0] q_push_id;
  logic [TW-1:0] q_head;
  logic          q_nonempty;

  logic          accept;
  logic          bad_id;
  logic [LW-1:0] m;
  logic          free_found;
  logic [TW-1:0] free_idx;
  logic [TW:0]   wtail_sum;
  logic [TW-1:0] wtail;
  logic [TW-1:0] whead_inc;
  logic          due;

  rrts_ready_q #(.TASK_SLOTS(TASK_SLOTS)) u_ready_q (
    .clk      (clk),
    .rst      (rst),
    .cmd      (q_cmd),
    .push_id  (q_push_id),
    .head_id  (q_head),
    .nonempty (q_nonempty)
  );

  assign req_stall = (state != S_IDLE) || (rsp_valid && rsp_stall);
  assign accept    = req_valid && !req_stall;
  assign bad_id    = {1'b0, mid} >= 9'(LOCK_COUNT);
  assign m         = mid[LW-1:0];
  assign wake_addr = scan_cnt[TW-1:0];
  assign due       = rd_vld && (task_state[rd_idx] == TS_SLEEP) && (tick_counter >= wake_rd);

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
      if (task_state[i] == TS_UNUSED) begin
        free_found = 1'b1;
        free_idx   = TW'(i);
      end
    end
    wtail_sum = (TW+1)'(whead[m]) + (TW+1)'(wcount[m]);
    if (wtail_sum >= (TW+1)'(TASK_SLOTS)) begin
      wtail_sum = wtail_sum - (TW+1)'(TASK_SLOTS);
    end
    wtail        = wtail_sum[TW-1:0];
    whead_inc    = (whead[m] == TW'(TASK_SLOTS - 1)) ? '0 : whead[m] + 1'b1;
    waiter_raddr = WAW'(m) * WAW'(TASK_SLOTS) + WAW'(whead[m]);
    waiter_waddr = WAW'(m) * WAW'(TASK_SLOTS) + WAW'(wtail);
  end

  // ready queue requests per state
  always_comb begin
    q_cmd     = '0;
    q_push_id = cur;
    unique case (state)
      S_EXEC: begin
        if (op == OP_CREATE && free_found) begin
          q_cmd.push = 1'b1;
          q_push_id  = free_idx;
        end
      end
      S_SCAN: begin
        q_cmd.push = due;
        q_push_id  = rd_idx;
      end
      S_UNLK_WR: begin
        q_cmd.push = 1'b1;
        q_push_id  = waiter_rd;
      end
      S_ROT: begin
        q_cmd.push = cur_valid && (task_state[cur] == TS_READY);
        q_cmd.pop  = 1'b1;
      end
      default: begin
        q_cmd = '0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_EXEC;
      S_EXEC: begin
        state_next = S_DONE;
        unique case (op)
          OP_TICK:  if (scheduler_enable) state_next = S_SCAN;
          OP_YIELD: state_next = S_ROT;
          OP_SLEEP, OP_EXIT: if (cur_valid) state_next = S_ROT;
          OP_LOCK: begin
            if (!bad_id && cur_valid && lock_held[m] && lock_owner[m] != cur) begin
              state_next = S_ROT;
            end
          end
          OP_UNLOCK: begin
            if (!bad_id && cur_valid && lock_held[m] && lock_owner[m] == cur) begin
              state_next = (wcount[m] != '0) ? S_UNLK_RD : S_ROT;
            end
          end
          default: state_next = S_DONE;
        endcase
      end
      S_SCAN:    if (!rd_vld && scan_cnt == CW'(TASK_SLOTS)) state_next = S_ROT;
      S_UNLK_RD: state_next = S_UNLK_WR;
      S_UNLK_WR: state_next = S_ROT;
      S_ROT:     state_next = S_DONE;
      S_DONE:    state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // memories: registered reads
  always_ff @(posedge clk) begin
    wake_rd   <= wake_mem[wake_addr];
    waiter_rd <= waiter_mem[waiter_raddr];
    if (state == S_EXEC && op == OP_SLEEP && cur_valid && ticks != '0) begin
      wake_mem[cur] <= tick_counter + ticks;
    end
    if (state == S_EXEC && op == OP_LOCK && !bad_id && cur_valid && lock_held[m]
        && lock_owner[m] != cur && wcount[m] < CW'(TASK_SLOTS)) begin
      waiter_mem[waiter_waddr] <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op    <= operation;
      ticks <= sleep_ticks;
      mid   <= mutex_id;
    end
    if (state == S_DONE) begin
      running_id    <= cur_valid ? 3'(cur) : 3'd0;
      running_ok    <= cur_valid;
      result_status <= status;
      created_id    <= 3'(created);
      time_now      <= tick_counter;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scheduler_enable <= 1'b0;
      tick_counter     <= '0;
      cur              <= '0;
      cur_valid        <= 1'b0;
      status           <= STS_OK;
      created          <= '0;
      rsp_valid        <= 1'b0;
      scan_cnt         <= '0;
      rd_vld           <= 1'b0;
      rd_idx           <= '0;
      for (int i = 0; i < TASK_SLOTS; i++) begin
        task_state[i] <= (i == 0) ? TS_READY : TS_UNUSED;
      end
      for (int i = 0; i < LOCK_COUNT; i++) begin
        lock_held[i]  <= 1'b0;
        lock_owner[i] <= '0;
        whead[i]      <= '0;
        wcount[i]     <= '0;
      end
    end else begin
      if (cfg_write_enable) scheduler_enable <= cfg_write_data;
      if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
      if (accept) begin
        status  <= STS_OK;
        created <= '0;
      end
      unique case (state)
        S_EXEC: begin
          scan_cnt <= '0;
          rd_vld   <= 1'b0;
          unique case (op)
            OP_TICK: tick_counter <= tick_counter + 32'd1;
            OP_CREATE: begin
              if (!free_found) begin
                status <= STS_FULL;
              end else begin
                task_state[free_idx] <= TS_READY;
                created              <= free_idx;
              end
            end
            OP_SLEEP: begin
              if (!cur_valid) status <= STS_NO_RUN;
              else if (ticks != '0) task_state[cur] <= TS_SLEEP;
            end
            OP_EXIT: begin
              if (!cur_valid) status <= STS_NO_RUN;
              else task_state[cur] <= TS_UNUSED;
            end
            OP_LOCK: begin
              if (bad_id) status <= STS_BAD_ID;
              else if (!cur_valid) status <= STS_NO_RUN;
              else if (!lock_held[m]) begin
                lock_held[m]  <= 1'b1;
                lock_owner[m] <= cur;
              end else if (lock_owner[m] != cur) begin
                task_state[cur] <= TS_BLOCKED;
                if (wcount[m] < CW'(TASK_SLOTS)) wcount[m] <= wcount[m] + 1'b1;
              end
            end
            OP_UNLOCK: begin
              if (bad_id) status <= STS_BAD_ID;
              else if (!cur_valid) status <= STS_NO_RUN;
              else if (!lock_held[m] || lock_owner[m] != cur) status <= STS_NOT_OWN;
              else if (wcount[m] == '0) lock_held[m] <= 1'b0;
            end
            default: status <= STS_OK;
          endcase
        end
        S_SCAN: begin
          // issue one wake-time read per cycle, test the slot read last cycle
          if (scan_cnt != CW'(TASK_SLOTS)) begin
            rd_vld   <= 1'b1;
            rd_idx   <= scan_cnt[TW-1:0];
            scan_cnt <= scan_cnt + 1'b1;
          end else begin
            rd_vld <= 1'b0;
          end
          if (due) task_state[rd_idx] <= TS_READY;
        end
        S_UNLK_WR: begin
          whead[m]              <= whead_inc;
          wcount[m]             <= wcount[m] - 1'b1;
          lock_owner[m]         <= waiter_rd;
          task_state[waiter_rd] <= TS_READY;
        end
        S_ROT: begin
          cur_valid <= q_nonempty;
          if (q_nonempty) cur <= q_head;
        end
        S_DONE: rsp_valid <= 1'b1;
        default: begin
        end
      endcase
    end
  end

endmodule

### hw/rtl/rrts_ready_q.sv
// Ready queue of task ids: FIFO with push and pop in the same cycle.
module rrts_ready_q #(
  parameter int TASK_SLOTS = rrts_pkg::TaskSlotsDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rrts_pkg::rq_cmd_t             cmd,
  input  logic [$clog2(TASK_SLOTS)-1:0] push_id,
  output logic [$clog2(TASK_SLOTS)-1:0] head_id,
  output logic                          nonempty
);
  import rrts_pkg::*;

  localparam int TW = $clog2(TASK_SLOTS);
  localparam int CW = $clog2(TASK_SLOTS + 1);

  logic [TW-1:0] fifo [TASK_SLOTS];
  logic [TW-1:0] head;
  logic [CW-1:0] count;
  logic          push_ok;
  logic          pop_ok;
  logic [TW:0]   tail_sum;
  logic [TW-1:0] tail;
  logic [TW-1:0] head_inc;

  assign push_ok  = cmd.push && (count < CW'(TASK_SLOTS));
  assign nonempty = (count != '0) || push_ok;
  assign pop_ok   = cmd.pop && nonempty;
  assign head_id  = (count == '0) ? push_id : fifo[head];

  always_comb begin
    tail_sum = (TW+1)'(head) + (TW+1)'(count);
    if (tail_sum >= (TW+1)'(TASK_SLOTS)) begin
      tail_sum = tail_sum - (TW+1)'(TASK_SLOTS);
    end
    tail = tail_sum[TW-1:0];
    head_inc = (head == TW'(TASK_SLOTS - 1)) ? '0 : head + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      count   <= CW'(1);
      fifo[0] <= '0;
    end else begin
      if (push_ok) begin
        fifo[tail] <= push_id;
      end
      if (pop_ok) begin
        head <= head_inc;
      end
      count <= count + CW'(push_ok) - CW'(pop_ok);
    end
  end

endmodule

### hw/rtl/rrts_checker.sv
// Port-level checks for the task scheduler, bound to the top level.
module rrts_assertions (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_stall,
  input logic [2:0]  running_id,
  input logic        running_ok,
  input logic [2:0]  result_status,
  input logic [2:0]  created_id,
  input logic [31:0] time_now
);
  import rrts_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(running_id) && $stable(time_now))
    else $error("stalled result changed");

  a_idle_id: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !running_ok |-> running_id == 3'd0)
    else $error("running id set with no running task");

  a_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> result_status <= STS_NO_RUN)
    else $error("status code out of range");

  a_created: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && created_id != 3'd0 |-> result_status == STS_OK)
    else $error("created slot reported with error status");

endmodule

bind round_robin_task_scheduler_unit rrts_assertions u_rrts_assertions (
  .clk           (clk),
  .rst           (rst),
  .rsp_valid     (rsp_valid),
  .rsp_stall     (rsp_stall),
  .running_id    (running_id),
  .running_ok    (running_ok),
  .result_status (result_status),
  .created_id    (created_id),
  .time_now      (time_now)
);

### tb/rrts_checker.sv
// Checker for the round-robin task scheduler: predicts each response and compares it.
module rrts_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_enable,
  input  logic        cfg_write_data,
  input  logic        req_valid,
  input  logic        req_stall,
  input  logic [2:0]  operation,
  input  logic [31:0] sleep_ticks,
  input  logic [7:0]  mutex_id,
  input  logic        rsp_valid,
  input  logic        rsp_stall,
  input  logic [2:0]  running_id,
  input  logic        running_ok,
  input  logic [2:0]  result_status,
  input  logic [2:0]  created_id,
  input  logic [31:0] time_now,
  output int          fail_count,
  output int          pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import rrts_pkg::*;

  localparam int NT = 8;
  localparam int NL = 8;

  typedef struct packed {
    logic [2:0]  run_id;
    logic        run_ok;
    logic [2:0]  status;
    logic [2:0]  new_id;
    logic [31:0] now;
  } sched_rsp_t;

  task_st_t    slot_st [NT];
  logic [31:0] wake_at [NT];
  logic [2:0]  rdy_q [NT];
  logic [2:0]  rdy_head;
  int          rdy_cnt;
  logic        held [NL];
  logic [2:0]  owner [NL];
  logic [2:0]  wait_q [NL][NT];
  logic [2:0]  wait_head [NL];
  int          wait_cnt [NL];
  logic [2:0]  cur;
  logic        cur_ok;
  logic [31:0] ticks_now;
  logic        sched_en;
  sched_rsp_t  rsp_expected [$];

  assign pending_count = rsp_expected.size();

  task automatic sched_reset();
    for (int i = 0; i < NT; i++) begin
      slot_st[i] = TS_UNUSED;
      wake_at[i] = '0;
      rdy_q[i] = '0;
    end
    for (int m = 0; m < NL; m++) begin
      held[m] = 1'b0;
      owner[m] = '0;
      wait_head[m] = '0;
      wait_cnt[m] = 0;
    end
    slot_st[0] = TS_READY;
    rdy_head = '0;
    rdy_cnt = 1;
    cur = '0;
    cur_ok = 1'b0;
    ticks_now = '0;
    sched_en = 1'b0;
  endtask

  function automatic void ready_enqueue(input logic [2:0] t);
    if (rdy_cnt < NT) begin
      rdy_q[3'(rdy_head + rdy_cnt)] = t;
      rdy_cnt++;
    end
  endfunction

  function automatic void switch_task();
    if (cur_ok && slot_st[cur] == TS_READY) ready_enqueue(cur);
    if (rdy_cnt == 0) begin
      cur_ok = 1'b0;
    end else begin
      cur = rdy_q[rdy_head];
      rdy_head = rdy_head + 3'd1;
      rdy_cnt--;
      cur_ok = 1'b1;
    end
  endfunction

  function automatic sched_rsp_t predict_event(input logic [2:0] op, input logic [31:0] dt,
                                               input logic [7:0] mid);
    sched_rsp_t r;
    logic [2:0] st;
    logic [2:0] nid;
    logic [2:0] m;
    logic [2:0] w;
    int         free_slot;
    st = STS_OK;
    nid = '0;
    m = mid[2:0];
    case (op)
      OP_TICK: begin
        ticks_now = ticks_now + 32'd1;
        if (sched_en) begin
          for (int i = 0; i < NT; i++)
            if (slot_st[i] == TS_SLEEP && ticks_now >= wake_at[i]) begin
              slot_st[i] = TS_READY;
              ready_enqueue(3'(i));
            end
          switch_task();
        end
      end
      OP_CREATE: begin
        free_slot = -1;
        for (int i = NT - 1; i >= 0; i--)
          if (slot_st[i] == TS_UNUSED) free_slot = i;
        if (free_slot < 0) begin
          st = STS_FULL;
        end else begin
          slot_st[free_slot] = TS_READY;
          ready_enqueue(3'(free_slot));
          nid = 3'(free_slot);
        end
      end
      OP_YIELD: switch_task();
      OP_SLEEP: begin
        if (!cur_ok) begin
          st = STS_NO_RUN;
        end else begin
          if (dt != 0) begin
            wake_at[cur] = ticks_now + dt;
            slot_st[cur] = TS_SLEEP;
          end
          switch_task();
        end
      end
      OP_EXIT: begin
        if (!cur_ok) begin
          st = STS_NO_RUN;
        end else begin
          slot_st[cur] = TS_UNUSED;
          switch_task();
        end
      end
      OP_LOCK: begin
        if (mid >= NL) st = STS_BAD_ID;
        else if (!cur_ok) st = STS_NO_RUN;
        else if (!held[m]) begin
          held[m] = 1'b1;
          owner[m] = cur;
        end else if (owner[m] != cur) begin
          slot_st[cur] = TS_BLOCKED;
          if (wait_cnt[m] < NT) begin
            wait_q[m][3'(wait_head[m] + wait_cnt[m])] = cur;
            wait_cnt[m]++;
          end
          switch_task();
        end
      end
      OP_UNLOCK: begin
        if (mid >= NL) st = STS_BAD_ID;
        else if (!cur_ok) st = STS_NO_RUN;
        else if (!held[m] || owner[m] != cur) st = STS_NOT_OWN;
        else begin
          if (wait_cnt[m] != 0) begin
            // hand the mutex straight to the first waiter
            w = wait_q[m][wait_head[m]];
            wait_head[m] = wait_head[m] + 3'd1;
            wait_cnt[m]--;
            owner[m] = w;
            slot_st[w] = TS_READY;
            ready_enqueue(w);
          end else begin
            held[m] = 1'b0;
          end
          switch_task();
        end
      end
      default: ;
    endcase
    r.run_id = cur_ok ? cur : 3'd0;
    r.run_ok = cur_ok;
    r.status = st;
    r.new_id = nid;
    r.now = ticks_now;
    return r;
  endfunction

  always @(posedge clk) begin
    sched_rsp_t exp_r;
    sched_rsp_t got;
    if (rst) begin
      sched_reset();
      rsp_expected.delete();
      fail_count <= 0;
    end else begin
      if (cfg_write_enable) sched_en = cfg_write_data;
      if (req_valid && !req_stall)
        rsp_expected.push_back(predict_event(operation, sleep_ticks, mutex_id));
      if (rsp_valid && !rsp_stall) begin
        got = '{running_id, running_ok, result_status, created_id, time_now};
        if (rsp_expected.size() == 0) begin
          $display("%0t: response with no request pending, got %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = rsp_expected.pop_front();
          if (got !== exp_r) begin
            $display("%0t: mismatch expected id=%0d ok=%0d st=%0d new=%0d t=%0d",
                     $time, exp_r.run_id, exp_r.run_ok, exp_r.status, exp_r.new_id, exp_r.now);
            $display("%0t:          actual   id=%0d ok=%0d st=%0d new=%0d t=%0d",
                     $time, got.run_id, got.run_ok, got.status, got.new_id, got.now);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

### tb/tb.sv
// Testbench top for the round-robin task scheduler: stimulus and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rrts_pkg::*;

  localparam int IdleLimit = 5000;

  logic        clk;
  logic        rst;
  logic        cfg_write_enable;
  logic        cfg_write_data;
  logic        req_valid;
  logic        req_stall;
  logic [2:0]  operation;
  logic [31:0] sleep_ticks;
  logic [7:0]  mutex_id;
  logic        rsp_valid;
  logic        rsp_stall;
  logic [2:0]  running_id;
  logic        running_ok;
  logic [2:0]  result_status;
  logic [2:0]  created_id;
  logic [31:0] time_now;
  int          fail_count;
  int          pending_count;
  logic        hold_off;
  int          idle_cycles;

  round_robin_task_scheduler_unit dut (
    .clk(clk), .rst(rst),
    .cfg_write_enable(cfg_write_enable), .cfg_write_data(cfg_write_data),
    .req_valid(req_valid), .req_stall(req_stall),
    .operation(operation), .sleep_ticks(sleep_ticks), .mutex_id(mutex_id),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .running_id(running_id), .running_ok(running_ok), .result_status(result_status),
    .created_id(created_id), .time_now(time_now)
  );

  rrts_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: own stall pattern, or a long hold-off on request
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (rst) rsp_stall <= 1'b0;
    else if (hold_off) rsp_stall <= 1'b1;
    else if (r < 40) rsp_stall <= 1'b0;
    else rsp_stall <= ($urandom_range(0, 3) == 0);
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic send_req(input logic [2:0] op, input logic [31:0] dt, input logic [7:0] mid);
    req_valid <= 1'b1;
    operation <= op;
    sleep_ticks <= dt;
    mutex_id <= mid;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic pause_req(input int n);
    req_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic write_enable(input logic v);
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_write_enable <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
  endtask

  task automatic random_req();
    int         p;
    logic [2:0] op;
    logic [31:0] dt;
    logic [7:0] mid;
    p = $urandom_range(0, 99);
    if (p < 25) op = OP_TICK;
    else if (p < 38) op = OP_CREATE;
    else if (p < 48) op = OP_YIELD;
    else if (p < 60) op = OP_SLEEP;
    else if (p < 66) op = OP_EXIT;
    else if (p < 81) op = OP_LOCK;
    else if (p < 97) op = OP_UNLOCK;
    else op = 3'd7;
    p = $urandom_range(0, 9);
    if (p == 0) dt = 32'd0;
    else if (p == 1) dt = $urandom;
    else dt = $urandom_range(1, 6);
    mid = ($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
    send_req(op, dt, mid);
  endtask

  initial begin
    int burst;
    hold_off = 1'b0;
    rst = 1'b1;
    cfg_write_enable = 1'b0;
    cfg_write_data = 1'b0;
    req_valid = 1'b0;
    operation = '0;
    sleep_ticks = '0;
    mutex_id = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: nothing running, disabled ticks, bad ids, unknown op
    send_req(OP_SLEEP, 32'd3, 8'd0);
    send_req(OP_EXIT, 32'd0, 8'd0);
    send_req(OP_LOCK, 32'd0, 8'd0);
    send_req(OP_UNLOCK, 32'd0, 8'd0);
    send_req(OP_LOCK, 32'd0, 8'hFF);
    send_req(OP_UNLOCK, 32'd0, 8'd8);
    send_req(OP_TICK, 32'hFFFF_FFFF, 8'hFF);
    send_req(3'd7, 32'd0, 8'd0);
    send_req(OP_YIELD, 32'd0, 8'd0);
    for (int i = 0; i < 8; i++) send_req(OP_CREATE, 32'd0, 8'd0);
    send_req(OP_LOCK, 32'd0, 8'd7);
    send_req(OP_LOCK, 32'd0, 8'd7);
    send_req(OP_UNLOCK, 32'd0, 8'd3);
    send_req(OP_YIELD, 32'd0, 8'd0);
    send_req(OP_LOCK, 32'd0, 8'd7);
    send_req(OP_SLEEP, 32'd0, 8'd0);
    send_req(OP_SLEEP, 32'hFFFF_FFFF, 8'd0);
    write_enable(1'b1);
    send_req(OP_TICK, 32'd0, 8'd0);
    send_req(OP_UNLOCK, 32'd0, 8'd7);
    send_req(OP_EXIT, 32'd0, 8'd0);

    // random phases across both enable settings
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin
        // long receiver hold-off while requests keep coming
        fork
          begin
            hold_off = 1'b1;
            repeat (300) @(posedge clk);
            hold_off = 1'b0;
          end
          for (int k = 0; k < 20; k++) random_req();
        join
      end
      for (int k = 0; k < 70;) begin
        burst = $urandom_range(1, 12);
        for (int b = 0; b < burst; b++) random_req();
        k += burst;
        if ($urandom_range(0, 2) != 0) pause_req($urandom_range(1, 30));
      end
      write_enable(ph % 3 != 0);
    end

    req_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (fail_count == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end
endmodule
